// ===== rtl/gbr_pkg.sv =====
// gbr_pkg: shared constants, types and helpers of the Gaussian blur block.
// Used by every file under rtl/; depends on nothing.
`default_nettype none

package gbr_pkg;

  // Kernel and line geometry
  localparam int KERNEL_SIZE = 3;
  localparam int MAX_WIDTH   = 2048;
  localparam int HALF_K      = KERNEL_SIZE / 2;
  localparam int NLINES      = KERNEL_SIZE - 1;
  localparam int COORD_LIMIT = 2048;

  // Pixel format: red in the top byte, blue in the bottom byte
  localparam int CH_W     = 8;
  localparam int NCH      = 3;
  localparam int PIX_W    = NCH * CH_W;
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;
  localparam int CH_MAX   = (1 << CH_W) - 1;

  // Coordinates and configured dimensions
  localparam int COORD_W = 11;
  localparam int DIM_W   = 12;

  // Arithmetic widths
  localparam int WT_W   = 16;
  localparam int FRAC_W = 16;
  localparam int NCLASS = 6;
  localparam int CLS_W  = 3;
  localparam int SUM_W  = 11;               // holds eight full-scale pixels; at most four share a class here
  localparam int PROD_W = SUM_W + WT_W;
  localparam int ACC_W  = PROD_W + 3;       // sum over the six classes
  localparam int INT_W  = ACC_W - FRAC_W;

  // Line store organization: one word per column holds every stored line
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int LS_W   = NLINES * PIX_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_R0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_R1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_R2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_R4    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_R5    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_R8    = 3'd7;

  // Distance classes (squared radius 0, 1, 2, 4, 5, 8)
  localparam logic [CLS_W-1:0] CLS_D0 = 3'd0;
  localparam logic [CLS_W-1:0] CLS_D1 = 3'd1;
  localparam logic [CLS_W-1:0] CLS_D2 = 3'd2;
  localparam logic [CLS_W-1:0] CLS_D4 = 3'd3;
  localparam logic [CLS_W-1:0] CLS_D5 = 3'd4;
  localparam logic [CLS_W-1:0] CLS_D8 = 3'd5;

  // Reset values of the registers
  localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd480;
  localparam logic [WT_W-1:0]  RST_W_D0   = 16'd13380;
  localparam logic [WT_W-1:0]  RST_W_D1   = 16'd8116;
  localparam logic [WT_W-1:0]  RST_W_D2   = 16'd4922;

  // Effective limits for the configured dimensions
  localparam logic [DIM_W-1:0] WIDTH_LIM =
      DIM_W'((MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT);
  localparam logic [DIM_W-1:0] HEIGHT_LIM = DIM_W'(COORD_LIMIT);

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [CH_W-1:0]    chan_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [ADDR_W-1:0]  ls_addr_t;
  typedef logic [LS_W-1:0]    ls_word_t;

  typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0]           column_t;
  typedef logic [NCLASS-1:0][WT_W-1:0]                 weight_arr_t;
  typedef logic [NCLASS-1:0][NCH-1:0][SUM_W-1:0]       csum_arr_t;
  typedef logic [NCLASS-1:0][NCH-1:0][PROD_W-1:0]      prod_arr_t;
  typedef logic [NCH-1:0][CH_W-1:0]                    rgb_t;

  // Reset weights by class, highest class first; 5x5-only classes start at zero
  localparam weight_arr_t RST_WEIGHTS =
      {WT_W'(0), WT_W'(0), WT_W'(0), RST_W_D2, RST_W_D1, RST_W_D0};

  // Position tag carried with an item down the pipeline
  typedef struct packed {
    coord_t row;
    coord_t col;
    logic   last;
  } gbr_meta_t;

  // Distance class of window tap (dy, dx)
  function automatic logic [CLS_W-1:0] dist_class(input int dy, input int dx);
    int oy;
    int ox;
    int d;
    logic [CLS_W-1:0] cls;
    oy = (dy > HALF_K) ? dy - HALF_K : HALF_K - dy;
    ox = (dx > HALF_K) ? dx - HALF_K : HALF_K - dx;
    d  = oy * oy + ox * ox;
    case (d)
      1:       cls = CLS_D1;
      2:       cls = CLS_D2;
      4:       cls = CLS_D4;
      5:       cls = CLS_D5;
      8:       cls = CLS_D8;
      default: cls = CLS_D0;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gbr_line_store.sv =====
// gbr_line_store: column-addressed memory holding the previous rows,
// with registered read and write-to-read forwarding. Uses gbr_pkg.
`default_nettype none

module gbr_line_store import gbr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     rd_en,
  input  ls_addr_t rd_addr,
  input  logic     wr_en,
  input  ls_addr_t wr_addr,
  input  ls_word_t wr_data,
  output ls_word_t rd_data
);

  ls_word_t mem [MAX_WIDTH];
  ls_word_t q_r;
  ls_word_t fwd_data_r;
  logic     fwd_r;

  // Storage array; read data holds until the next read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // Same-address write and read in one cycle: take the new word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

  // A read colliding with a write returns the written word
  a_fwd_hit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))
    else $error("line store forwarding returned stale data");

endmodule

`default_nettype wire

// ===== rtl/gbr_window.sv =====
// gbr_window: KxK sliding window and the per-class pixel sum stage.
// Uses gbr_pkg; fed by the line-store stage of the top level.
`default_nettype none

module gbr_window import gbr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  input  logic      up_emit,
  input  gbr_meta_t up_meta,
  input  column_t   up_column,
  output logic      up_free,
  output logic      dn_valid,
  output gbr_meta_t dn_meta,
  output csum_arr_t dn_sums,
  input  logic      dn_free
);

  logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] win_r;
  logic      s2_valid_r;
  gbr_meta_t s2_meta_r;
  logic      s3_valid_r;
  gbr_meta_t s3_meta_r;
  csum_arr_t s3_sums_r;
  csum_arr_t sums;
  logic      free2;
  logic      free3;
  logic      shift;

  assign free3   = !s3_valid_r || dn_free;
  assign free2   = !s2_valid_r || free3;
  assign shift   = up_valid && free2;
  assign up_free = free2;

  // Every transfer shifts the window; only interior pixels go on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (free2) begin
        s2_valid_r <= up_valid && up_emit;
      end
      if (free3) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int dy = 0; dy < KERNEL_SIZE; dy++) begin
        for (int dx = 0; dx < KERNEL_SIZE - 1; dx++) begin
          win_r[dy][dx] <= win_r[dy][dx+1];
        end
        win_r[dy][KERNEL_SIZE-1] <= up_column[dy];
      end
    end
    if (free2) begin
      s2_meta_r <= up_meta;
    end
    if (free3) begin
      s3_meta_r <= s2_meta_r;
      s3_sums_r <= sums;
    end
  end

  // Taps at the same radius share a weight: add them first
  always_comb begin
    sums = '0;
    for (int dy = 0; dy < KERNEL_SIZE; dy++) begin
      for (int dx = 0; dx < KERNEL_SIZE; dx++) begin
        for (int ch = 0; ch < NCH; ch++) begin
          sums[dist_class(dy, dx)][ch] = sums[dist_class(dy, dx)][ch]
                                       + SUM_W'(win_r[dy][dx][ch*CH_W +: CH_W]);
        end
      end
    end
  end

  assign dn_valid = s3_valid_r;
  assign dn_meta  = s3_meta_r;
  assign dn_sums  = s3_sums_r;

  // A held snapshot must not be shifted away
  a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !free3 |=> $stable(win_r))
    else $error("window shifted under a stalled item");

  // Nothing enters the sum stage while it is blocked
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !dn_free |=> s3_valid_r && $stable(s3_sums_r))
    else $error("class sums changed while stalled");

endmodule

`default_nettype wire

// ===== rtl/gbr_mac.sv =====
// gbr_mac: weight multiply stage, class accumulation, clamp and the
// output register. Uses gbr_pkg; fed by gbr_window.
`default_nettype none

module gbr_mac import gbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  input  gbr_meta_t   up_meta,
  input  csum_arr_t   up_sums,
  input  weight_arr_t weights,
  output logic        up_free,
  output logic        out_valid,
  input  logic        out_stall,
  output rgb_t        out_rgb,
  output gbr_meta_t   out_meta
);

  logic      s4_valid_r;
  gbr_meta_t s4_meta_r;
  prod_arr_t s4_prod_r;
  logic      o_valid_r;
  gbr_meta_t o_meta_r;
  rgb_t      o_rgb_r;
  rgb_t      rgb;
  logic      free4;
  logic      free5;

  assign free5   = !o_valid_r || !out_stall;
  assign free4   = !s4_valid_r || free5;
  assign up_free = free4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (free4) begin
        s4_valid_r <= up_valid;
      end
      if (free5) begin
        o_valid_r <= s4_valid_r;
      end
    end
  end

  // One small multiplier per class and channel
  always_ff @(posedge clk) begin
    if (free4) begin
      s4_meta_r <= up_meta;
      for (int c = 0; c < NCLASS; c++) begin
        for (int ch = 0; ch < NCH; ch++) begin
          s4_prod_r[c][ch] <= PROD_W'(up_sums[c][ch]) * PROD_W'(weights[c]);
        end
      end
    end
  end

  // Sum the classes, drop the fraction, saturate
  always_comb begin
    logic [ACC_W-1:0] acc;
    logic [INT_W-1:0] ipart;
    for (int ch = 0; ch < NCH; ch++) begin
      acc = '0;
      for (int c = 0; c < NCLASS; c++) begin
        acc = acc + ACC_W'(s4_prod_r[c][ch]);
      end
      ipart = acc[ACC_W-1:FRAC_W];
      rgb[ch] = (ipart > INT_W'(CH_MAX)) ? CH_W'(CH_MAX) : ipart[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (free5) begin
      o_meta_r <= s4_meta_r;
      o_rgb_r  <= rgb;
    end
  end

  assign out_valid = o_valid_r;
  assign out_rgb   = o_rgb_r;
  assign out_meta  = o_meta_r;

endmodule

`default_nettype wire

// ===== rtl/gaussian_blur_rgb.sv =====
// gaussian_blur_rgb: top level of the 3x3 Gaussian blur on an RGB raster.
// Depends on gbr_pkg, gbr_line_store, gbr_window and gbr_mac.
//
//   port group | direction | handshake          | payload
//   in_*       | input     | in_valid/in_stall  | pixel RGB, frame_start
//   out_*      | output    | out_valid/out_stall| blurred RGB, row, col, frame_last
//   cfg_*      | input     | cfg_wr_en          | cfg_index, cfg_data
//
// One pixel per clock sustained while out_stall is low; the line store's
// read-modify-write of one column word per pixel (one read and one write
// port) sets that rate. A result passes the line-store read, window, class-sum,
// product and output registers on its way to out_*. Border pixels cause no result.
// Synchronous active-low reset clears the counters, the pipeline valids and
// the registers; the line store needs no clearing pass. Output stalls back
// up stage by stage into in_stall.
`default_nettype none

module gaussian_blur_rgb import gbr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CH_W-1:0]       in_pix_red,
  input  logic [CH_W-1:0]       in_pix_green,
  input  logic [CH_W-1:0]       in_pix_blue,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic [COORD_W-1:0]    out_row,
  output logic [COORD_W-1:0]    out_col,
  output logic                  out_frame_last,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dim_t        width_r;
  dim_t        height_r;
  weight_arr_t weight_r;
  dim_t        eff_w;
  dim_t        eff_h;

  coord_t      col_count_r;
  coord_t      row_count_r;
  dim_t        c0;
  dim_t        r0;
  dim_t        c1;
  dim_t        r1;
  logic        emit0;
  gbr_meta_t   meta0;

  logic        s1_valid_r;
  logic        s1_emit_r;
  gbr_meta_t   s1_meta_r;
  pix_t        s1_pix_r;
  ls_addr_t    s1_addr_r;

  logic        free1;
  logic        in_accept;
  logic        s1_move;
  logic        win_free;
  ls_word_t    ls_rd;
  ls_word_t    ls_wr;
  column_t     column;
  pix_t        pix_in;

  logic        win_valid;
  gbr_meta_t   win_meta;
  csum_arr_t   win_sums;
  logic        mac_free;
  rgb_t        res_rgb;
  gbr_meta_t   res_meta;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      weight_r <= RST_WEIGHTS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r          <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_r         <= cfg_data[DIM_W-1:0];
        CFG_WEIGHT_R0:    weight_r[CLS_D0] <= cfg_data[WT_W-1:0];
        CFG_WEIGHT_R1:    weight_r[CLS_D1] <= cfg_data[WT_W-1:0];
        CFG_WEIGHT_R2:    weight_r[CLS_D2] <= cfg_data[WT_W-1:0];
        CFG_WEIGHT_R4:    weight_r[CLS_D4] <= cfg_data[WT_W-1:0];
        CFG_WEIGHT_R5:    weight_r[CLS_D5] <= cfg_data[WT_W-1:0];
        CFG_WEIGHT_R8:    weight_r[CLS_D8] <= cfg_data[WT_W-1:0];
      endcase
    end
  end

  // Zero or oversize dimensions fall back to the limit
  assign eff_w = (width_r == '0 || width_r > WIDTH_LIM) ? WIDTH_LIM : width_r;
  assign eff_h = (height_r == '0 || height_r > HEIGHT_LIM) ? HEIGHT_LIM : height_r;

  // Position of the incoming pixel and of the one after it
  always_comb begin
    c0 = in_frame_start ? '0 : {1'b0, col_count_r};
    r0 = in_frame_start ? '0 : {1'b0, row_count_r};
    if (c0 >= eff_w) begin
      c0 = '0;
      r0 = r0 + dim_t'(1);
    end
    if (r0 >= eff_h) begin
      r0 = '0;
    end
    c1 = c0 + dim_t'(1);
    r1 = r0;
    if (c1 >= eff_w) begin
      c1 = '0;
      r1 = r0 + dim_t'(1);
    end
    if (r1 >= eff_h) begin
      r1 = '0;
    end
  end

  assign emit0      = (r0 >= dim_t'(KERNEL_SIZE - 1)) && (c0 >= dim_t'(KERNEL_SIZE - 1));
  assign meta0.row  = COORD_W'(r0 - dim_t'(HALF_K));
  assign meta0.col  = COORD_W'(c0 - dim_t'(HALF_K));
  assign meta0.last = (r0 == eff_h - dim_t'(1)) && (c0 == eff_w - dim_t'(1));
  assign pix_in     = {in_pix_red, in_pix_green, in_pix_blue};

  // Line-store read stage
  assign free1     = !s1_valid_r || win_free;
  assign in_accept = in_valid && free1;
  assign s1_move   = s1_valid_r && win_free;
  assign in_stall  = !free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      col_count_r <= '0;
      row_count_r <= '0;
    end else begin
      if (free1) begin
        s1_valid_r <= in_valid;
      end
      if (in_accept) begin
        col_count_r <= c1[COORD_W-1:0];
        row_count_r <= r1[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      s1_emit_r <= emit0;
      s1_meta_r <= meta0;
      s1_pix_r  <= pix_in;
      s1_addr_r <= ls_addr_t'(c0);
    end
  end

  // Oldest line drops out, the new pixel becomes the newest line
  assign ls_wr = {s1_pix_r, ls_rd[LS_W-1:PIX_W]};

  always_comb begin
    for (int i = 0; i < NLINES; i++) begin
      column[i] = ls_rd[i*PIX_W +: PIX_W];
    end
    column[NLINES] = s1_pix_r;
  end

  gbr_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (ls_addr_t'(c0)),
    .wr_en   (s1_move),
    .wr_addr (s1_addr_r),
    .wr_data (ls_wr),
    .rd_data (ls_rd)
  );

  gbr_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s1_valid_r),
    .up_emit   (s1_emit_r),
    .up_meta   (s1_meta_r),
    .up_column (column),
    .up_free   (win_free),
    .dn_valid  (win_valid),
    .dn_meta   (win_meta),
    .dn_sums   (win_sums),
    .dn_free   (mac_free)
  );

  gbr_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (win_valid),
    .up_meta   (win_meta),
    .up_sums   (win_sums),
    .weights   (weight_r),
    .up_free   (mac_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rgb   (res_rgb),
    .out_meta  (res_meta)
  );

  assign out_red        = res_rgb[CH_RED];
  assign out_green      = res_rgb[CH_GREEN];
  assign out_blue       = res_rgb[CH_BLUE];
  assign out_row        = res_meta.row;
  assign out_col        = res_meta.col;
  assign out_frame_last = res_meta.last;

  // Counters always land inside the frame they were computed for
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> ({1'b0, col_count_r} < $past(eff_w))
               && ({1'b0, row_count_r} < $past(eff_h)))
    else $error("raster counters left the frame");

  // The read stage only empties into the window
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !win_free |=> s1_valid_r && $stable(s1_addr_r))
    else $error("line-store stage lost a stalled pixel");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for gaussian_blur_rgb: random RGB raster frames under
// random sender gaps and receiver stalls, checked against a built-in predictor.
// Depends on gbr_pkg and the gaussian_blur_rgb RTL.

module testbench;
  import gbr_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int SETTLE      = 12;    // margin for the result pipeline to empty and for bubbles
  localparam int RAND_PIXELS = 1950;

  // One blurred pixel as it leaves the block
  typedef struct packed {
    chan_t  red;
    chan_t  green;
    chan_t  blue;
    coord_t row;
    coord_t col;
    logic   last;
  } blur_pix_t;

  // Blur predictor plus the queue of blurred pixels still owed by the block
  class blur_scoreboard;
    bit [PIX_W-1:0] line_mem [NLINES][MAX_WIDTH];
    bit [PIX_W-1:0] win [KERNEL_SIZE][KERNEL_SIZE];
    int unsigned    col_pos;
    int unsigned    row_pos;
    bit [15:0]      regs [8];
    blur_pix_t      owed [$];
    int             errors;

    function new();
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
      regs[CFG_IMAGE_WIDTH]  = 16'(RST_WIDTH);
      regs[CFG_IMAGE_HEIGHT] = 16'(RST_HEIGHT);
      regs[CFG_WEIGHT_R0]    = RST_W_D0;
      regs[CFG_WEIGHT_R1]    = RST_W_D1;
      regs[CFG_WEIGHT_R2]    = RST_W_D2;
      regs[CFG_WEIGHT_R4]    = '0;
      regs[CFG_WEIGHT_R5]    = '0;
      regs[CFG_WEIGHT_R8]    = '0;
    endfunction

    // dimension registers keep only their low DIM_W bits
    function void set_reg(int idx, bit [15:0] val);
      if (idx == CFG_IMAGE_WIDTH || idx == CFG_IMAGE_HEIGHT) begin
        regs[idx] = 16'(val[DIM_W-1:0]);
      end else begin
        regs[idx] = val;
      end
    endfunction

    function int unsigned eff_width();
      int unsigned lim;
      int unsigned w;
      lim = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;
      w   = regs[CFG_IMAGE_WIDTH];
      if (w == 0 || w > lim) w = lim;
      return w;
    endfunction

    function int unsigned eff_height();
      int unsigned h;
      h = regs[CFG_IMAGE_HEIGHT];
      if (h == 0 || h > COORD_LIMIT) h = COORD_LIMIT;
      return h;
    endfunction

    function void wrap_pos(int unsigned w, int unsigned h);
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
    endfunction

    // weight by squared distance from the window center
    function int unsigned tap_weight(int unsigned d);
      case (d)
        0:       return regs[CFG_WEIGHT_R0];
        1:       return regs[CFG_WEIGHT_R1];
        2:       return regs[CFG_WEIGHT_R2];
        4:       return regs[CFG_WEIGHT_R4];
        5:       return regs[CFG_WEIGHT_R5];
        8:       return regs[CFG_WEIGHT_R8];
        default: return 0;
      endcase
    endfunction

    // drop the Q.16 fraction, saturate at full scale
    function chan_t clamp_chan(int unsigned acc);
      int unsigned v;
      v = acc >> FRAC_W;
      return (v > CH_MAX) ? chan_t'(CH_MAX) : chan_t'(v);
    endfunction

    // accepted input pixel: update stores, owe a result for interior pixels
    function void note_pixel(chan_t r, chan_t g, chan_t b, bit fs);
      int unsigned    w, h, c, rw, oy, ox, wt;
      int unsigned    acc_r, acc_g, acc_b;
      bit [PIX_W-1:0] pix, p;
      bit [PIX_W-1:0] colv [KERNEL_SIZE];
      blur_pix_t      res;
      w = eff_width();
      h = eff_height();
      pix = '0;
      pix[CH_RED*CH_W +: CH_W]   = r;
      pix[CH_GREEN*CH_W +: CH_W] = g;
      pix[CH_BLUE*CH_W +: CH_W]  = b;
      if (fs) begin
        col_pos = 0;
        row_pos = 0;
      end
      wrap_pos(w, h);
      c  = col_pos;
      rw = row_pos;

      // column of stored lines plus the new pixel; shift the lines up
      for (int i = 0; i < NLINES; i++) colv[i] = line_mem[i][c];
      colv[NLINES] = pix;
      for (int i = 0; i + 1 < NLINES; i++) line_mem[i][c] = line_mem[i+1][c];
      line_mem[NLINES-1][c] = pix;

      // window slides one column left
      for (int dy = 0; dy < KERNEL_SIZE; dy++) begin
        for (int dx = 0; dx + 1 < KERNEL_SIZE; dx++) win[dy][dx] = win[dy][dx+1];
        win[dy][KERNEL_SIZE-1] = colv[dy];
      end

      if (rw >= KERNEL_SIZE - 1 && c >= KERNEL_SIZE - 1) begin
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        for (int dy = 0; dy < KERNEL_SIZE; dy++) begin
          for (int dx = 0; dx < KERNEL_SIZE; dx++) begin
            oy = (dy > HALF_K) ? dy - HALF_K : HALF_K - dy;
            ox = (dx > HALF_K) ? dx - HALF_K : HALF_K - dx;
            wt = tap_weight(oy * oy + ox * ox);
            p  = win[dy][dx];
            acc_r += p[CH_RED*CH_W +: CH_W] * wt;
            acc_g += p[CH_GREEN*CH_W +: CH_W] * wt;
            acc_b += p[CH_BLUE*CH_W +: CH_W] * wt;
          end
        end
        res.red   = clamp_chan(acc_r);
        res.green = clamp_chan(acc_g);
        res.blue  = clamp_chan(acc_b);
        res.row   = coord_t'(rw - HALF_K);
        res.col   = coord_t'(c - HALF_K);
        res.last  = (rw == h - 1 && c == w - 1);
        owed.push_back(res);
      end

      col_pos = c + 1;
      wrap_pos(w, h);
    endfunction

    function void cmp(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      end
    endfunction

    // accepted result: compare with the oldest owed pixel
    function void check_result(blur_pix_t got);
      blur_pix_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got row %0d col %0d rgb %0d %0d %0d",
                 $time, got.row, got.col, got.red, got.green, got.blue);
        return;
      end
      want = owed.pop_front();
      cmp("red", 32'(want.red), 32'(got.red));
      cmp("green", 32'(want.green), 32'(got.green));
      cmp("blue", 32'(want.blue), 32'(got.blue));
      cmp("row", 32'(want.row), 32'(got.row));
      cmp("col", 32'(want.col), 32'(got.col));
      cmp("frame_last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CH_W-1:0]       in_pix_red = '0;
  logic [CH_W-1:0]       in_pix_green = '0;
  logic [CH_W-1:0]       in_pix_blue = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic [COORD_W-1:0]    out_row;
  logic [COORD_W-1:0]    out_col;
  logic                  out_frame_last;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int             send_idle_pct = 0;
  int             stall_pct = 0;
  int             quiet_cycles = 0;
  int             pixels_sent = 0;
  bit [15:0]      reg_plan [8];
  blur_scoreboard sb = new();

  gaussian_blur_rgb dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pix_red     (in_pix_red),
    .in_pix_green   (in_pix_green),
    .in_pix_blue    (in_pix_blue),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // observe both channels at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        sb.note_pixel(in_pix_red, in_pix_green, in_pix_blue, in_frame_start);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        sb.check_result('{out_red, out_green, out_blue, out_row, out_col, out_frame_last});
      end
    end
  end

  // watchdog: no transfer of any kind for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic chan_t pick_chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return chan_t'(CH_MAX);
      default: return chan_t'($urandom_range(CH_MAX));
    endcase
  endfunction

  // fill the weight part of reg_plan
  task automatic pick_weights();
    int unsigned a;
    int unsigned b;
    case ($urandom_range(5))
      0: begin  // every weight at full scale: saturates
        for (int i = CFG_WEIGHT_R0; i <= CFG_WEIGHT_R8; i++) reg_plan[i] = 16'hFFFF;
      end
      1: begin
        for (int i = CFG_WEIGHT_R0; i <= CFG_WEIGHT_R8; i++) reg_plan[i] = 16'h0000;
      end
      2: begin
        for (int i = CFG_WEIGHT_R0; i <= CFG_WEIGHT_R8; i++) reg_plan[i] = 16'($urandom);
      end
      default: begin  // kernel summing to just under one
        a = $urandom_range(8191);
        b = $urandom_range(8191);
        reg_plan[CFG_WEIGHT_R1] = 16'(a);
        reg_plan[CFG_WEIGHT_R2] = 16'(b);
        reg_plan[CFG_WEIGHT_R0] = 16'(65535 - 4 * (a + b) - $urandom_range(7));
        reg_plan[CFG_WEIGHT_R4] = 16'($urandom);
        reg_plan[CFG_WEIGHT_R5] = 16'($urandom);
        reg_plan[CFG_WEIGHT_R8] = 16'($urandom);
      end
    endcase
  endtask

  // write all registers back to back; block must be idle
  task automatic program_regs();
    for (int i = CFG_IMAGE_WIDTH; i <= CFG_WEIGHT_R8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= reg_plan[i];
      @(posedge clk);
      sb.set_reg(i, reg_plan[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // one input transfer, with random sender gaps ahead of it
  task automatic send_pixel(chan_t r, chan_t g, chan_t b, bit fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pix_red     <= r;
    in_pix_green   <= g;
    in_pix_blue    <= b;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pixels_sent++;
  endtask

  // raster pixels; frame_start on the first, sometimes on frame boundaries,
  // and rarely mid frame
  task automatic send_frames(int n_pix);
    int unsigned fsize;
    bit          fs;
    fsize = sb.eff_width() * sb.eff_height();
    for (int k = 0; k < n_pix; k++) begin
      fs = (k == 0) || (k % fsize == 0 && $urandom_range(1) == 1) ||
           ($urandom_range(199) == 0);
      send_pixel(pick_chan(), pick_chan(), pick_chan(), fs);
    end
  endtask

  // wait out every owed result, then let the pipeline empty; the first
  // edge lets the monitor note the last transfer
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_pace(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 51; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 51; end
      default: begin send_idle_pct = 6; stall_pct = 6; end
    endcase
  endtask

  initial begin
    int          phase;
    int          rand_start;
    int unsigned w;
    int unsigned h;
    int          n;
    bit [15:0]   wide_codes [4];
    bit [15:0]   tall_codes [4];
    wide_codes = '{16'h0000, 16'h0FFF, 16'h0800, 16'hF801};
    tall_codes = '{16'h0000, 16'hF000, 16'h0800, 16'h0FFF};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame with the stock weights, then a second frame by wrap alone
    set_pace(0);
    reg_plan[CFG_IMAGE_WIDTH]  = 16'd3;
    reg_plan[CFG_IMAGE_HEIGHT] = 16'd3;
    reg_plan[CFG_WEIGHT_R0]    = RST_W_D0;
    reg_plan[CFG_WEIGHT_R1]    = RST_W_D1;
    reg_plan[CFG_WEIGHT_R2]    = RST_W_D2;
    reg_plan[CFG_WEIGHT_R4]    = 16'h0000;
    reg_plan[CFG_WEIGHT_R5]    = 16'h0000;
    reg_plan[CFG_WEIGHT_R8]    = 16'h0000;
    program_regs();
    for (int k = 0; k < 18; k++) begin
      send_pixel((k % 2 == 1) ? chan_t'(CH_MAX) : chan_t'(0),
                 (k % 3 == 0) ? chan_t'(CH_MAX) : chan_t'(0),
                 ((k / 2) % 2 == 1) ? chan_t'(CH_MAX) : chan_t'(0), k == 0);
    end
    drain();

    // image smaller than the kernel: nothing comes out
    reg_plan[CFG_IMAGE_WIDTH]  = 16'd2;
    reg_plan[CFG_IMAGE_HEIGHT] = 16'd2;
    pick_weights();
    program_regs();
    send_frames(4);
    drain();

    // zero width and oversized height both mean the 2048 limit
    reg_plan[CFG_IMAGE_WIDTH]  = 16'h0000;
    reg_plan[CFG_IMAGE_HEIGHT] = 16'hFFFF;
    program_regs();
    send_frames(6);
    drain();

    // random phases, each starting from an idle block and a fresh frame
    phase = 0;
    rand_start = pixels_sent;
    while (pixels_sent - rand_start < RAND_PIXELS) begin
      set_pace(phase);
      case ($urandom_range(19))
        0: begin  // widest rows, too few rows for a result
          reg_plan[CFG_IMAGE_WIDTH]  = wide_codes[$urandom_range(3)];
          reg_plan[CFG_IMAGE_HEIGHT] = 16'($urandom_range(1, 2));
          n = $urandom_range(12, 30);
        end
        1: begin  // tallest frame, narrow rows
          w = $urandom_range(3, 5);
          reg_plan[CFG_IMAGE_WIDTH]  = 16'(w);
          reg_plan[CFG_IMAGE_HEIGHT] = tall_codes[$urandom_range(3)];
          n = w * $urandom_range(10, 20);
        end
        2, 3: begin  // one side below the kernel size
          if ($urandom_range(1) == 1) begin
            reg_plan[CFG_IMAGE_WIDTH]  = 16'($urandom_range(1, 2));
            reg_plan[CFG_IMAGE_HEIGHT] = 16'($urandom_range(1, 8));
          end else begin
            reg_plan[CFG_IMAGE_WIDTH]  = 16'($urandom_range(1, 8));
            reg_plan[CFG_IMAGE_HEIGHT] = 16'($urandom_range(1, 2));
          end
          n = $urandom_range(6, 20);
        end
        default: begin  // ordinary small frames, unused upper bits set at random
          w = $urandom_range(3, 16);
          h = $urandom_range(3, 10);
          reg_plan[CFG_IMAGE_WIDTH]  = {4'($urandom), 12'(w)};
          reg_plan[CFG_IMAGE_HEIGHT] = {4'($urandom), 12'(h)};
          n = w * h * $urandom_range(1, 2) + $urandom_range(0, w * h - 1);
        end
      endcase
      // last phase stops at the pixel budget
      if (n > RAND_PIXELS - (pixels_sent - rand_start)) begin
        n = RAND_PIXELS - (pixels_sent - rand_start);
      end
      pick_weights();
      program_regs();
      send_frames(n);
      drain();
      phase++;
    end

    repeat (2 * SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
